### hw/rtl/spq_pkg.sv
package spq_pkg;

   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 8;

   localparam int VALUE_W   = 32;
   localparam int PRIO_IN_W = 8;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_DELETE = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

### hw/rtl/spq_store.sv
module spq_store #(
   parameter int DEPTH = spq_pkg::CAPACITY_DEF,
   parameter int WIDTH = spq_pkg::VALUE_W + spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sorted_priority_queue.sv
// Channel   Ports                                   Handshake
// request   req_func, req_item_value,               start & !busy
//           req_item_priority
// response  rsp_popped_value, rsp_status,           rsp_strobe, one cycle
//           rsp_occupancy, rsp_removed_count
//
// Push and rejected requests go from accept straight to the finish state, which registers the strobe.
// Other insert, pop and delete requests walk the entry memory once, one entry per cycle.
// busy is high from accept until the strobe; start is ignored meanwhile.
// Synchronous reset empties the queue; no memory clearing pass.
// The response beat cannot be stalled.
module sorted_priority_queue #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
   localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [spq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [spq_pkg::PRIO_IN_W-1:0]       req_item_priority,
   output logic                                rsp_strobe,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_popped_value,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]                    rsp_occupancy,
   output logic [CNT_W-1:0]                    rsp_removed_count
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int PB     = PRIORITY_BITS;
   localparam int VW     = spq_pkg::VALUE_W;
   localparam int EW     = VW + PB;
   localparam int PEXT_W = (PB > spq_pkg::PRIO_IN_W) ? PB : spq_pkg::PRIO_IN_W;

   spq_pkg::state_type  state_ff, state_in;
   spq_pkg::func_type   func_ff, func_in;
   spq_pkg::status_type status_ff, status_in;
   logic [PB-1:0]       prio_ff, prio_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    keep_ff, keep_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                placed_ff, placed_in;
   logic [EW-1:0]       carry_ff, carry_in;
   logic [VW-1:0]       popped_ff, popped_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [VW-1:0]       rsp_popped_ff, rsp_popped_in;
   logic [spq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic [CNT_W-1:0]    rsp_rem_ff, rsp_rem_in;

   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [EW-1:0]       wr_data, rd_data;
   logic [PEXT_W-1:0]   req_prio_ext;
   logic [PB-1:0]       req_prio;
   logic [PB-1:0]       rd_prio;
   logic                full, drop;

   spq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_prio_ext = PEXT_W'(req_item_priority);
   assign req_prio     = req_prio_ext[PB-1:0];
   assign rd_prio      = rd_data[PB-1:0];
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign busy         = (state_ff != spq_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      status_in     = status_ff;
      prio_in       = prio_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      keep_in       = keep_ff;
      rd_idx_in     = ptr_ff;
      rd_vld_in     = 1'b0;
      placed_in     = placed_ff;
      carry_in      = carry_ff;
      popped_in     = popped_ff;
      rsp_strobe_in = 1'b0;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_rem_in    = rsp_rem_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = carry_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];
      drop          = 1'b0;

      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (start) begin
               func_in   = spq_pkg::func_type'(req_func);
               prio_in   = req_prio;
               ptr_in    = '0;
               keep_in   = '0;
               placed_in = 1'b0;
               popped_in = '0;
               status_in = spq_pkg::STATUS_OK;
               carry_in  = {req_item_value, req_prio};
               state_in  = spq_pkg::ST_WALK;
               unique case (spq_pkg::func_type'(req_func))
                  spq_pkg::FUNC_PUSH: begin
                     carry_in  = {req_item_value, PB'(0)};
                     status_in = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
                     state_in  = spq_pkg::ST_FINISH;
                  end
                  spq_pkg::FUNC_INSERT: begin
                     if (full) begin
                        status_in = spq_pkg::STATUS_FULL;
                        state_in  = spq_pkg::ST_FINISH;
                     end
                  end
                  spq_pkg::FUNC_POP: begin
                     if (count_ff == '0) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                        state_in  = spq_pkg::ST_FINISH;
                     end
                  end
                  spq_pkg::FUNC_DELETE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         spq_pkg::ST_WALK: begin
            rd_en     = (ptr_ff < count_ff);
            rd_vld_in = rd_en;
            if (rd_en) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (func_ff == spq_pkg::FUNC_INSERT) begin
                  // displaced entries ripple one slot toward the tail
                  if (placed_ff || (rd_prio < prio_ff)) begin
                     wr_en     = 1'b1;
                     wr_addr   = rd_idx_ff[IDX_W-1:0];
                     wr_data   = carry_ff;
                     carry_in  = rd_data;
                     placed_in = 1'b1;
                  end
               end else begin
                  drop = ((func_ff == spq_pkg::FUNC_POP) && (rd_idx_ff == '0)) ||
                         ((func_ff == spq_pkg::FUNC_DELETE) && (rd_prio == prio_ff));
                  if ((func_ff == spq_pkg::FUNC_POP) && (rd_idx_ff == '0)) begin
                     popped_in = rd_data[EW-1 -: VW];
                  end
                  if (!drop) begin
                     wr_en   = 1'b1;
                     wr_addr = keep_ff[IDX_W-1:0];
                     wr_data = rd_data;
                     keep_in = keep_ff + CNT_W'(1);
                  end
               end
            end
            if (!rd_en && !rd_vld_ff) begin
               state_in = spq_pkg::ST_FINISH;
            end
         end

         spq_pkg::ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_popped_in = popped_ff;
            rsp_status_in = status_ff;
            if ((func_ff == spq_pkg::FUNC_PUSH) || (func_ff == spq_pkg::FUNC_INSERT)) begin
               rsp_rem_in = '0;
               if (status_ff == spq_pkg::STATUS_OK) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               rsp_rem_in = count_ff - keep_ff;
               count_in   = keep_ff;
            end
            rsp_occ_in = count_in;
            state_in   = spq_pkg::ST_IDLE;
         end

         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spq_pkg::ST_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      status_ff     <= status_in;
      prio_ff       <= prio_in;
      ptr_ff        <= ptr_in;
      keep_ff       <= keep_in;
      rd_idx_ff     <= rd_idx_in;
      placed_ff     <= placed_in;
      carry_ff      <= carry_in;
      popped_ff     <= popped_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_rem_ff    <= rsp_rem_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_popped_value  = rsp_popped_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_removed_count = rsp_rem_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == spq_pkg::ST_IDLE))
      else $error("response beat while still busy");

   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == spq_pkg::ST_WALK))
      else $error("read data returned outside walk");

   a_walk_write_behind: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == spq_pkg::ST_WALK)) |->
         (CNT_W'(wr_addr) <= rd_idx_ff) && (rd_idx_ff < count_ff))
      else $error("walk write ahead of read pointer");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == spq_pkg::STATUS_FULL)) |->
         (rsp_occ_ff == CNT_W'(CAPACITY)))
      else $error("full status with free entries");

endmodule

### verif/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

   localparam int CAPACITY       = spq_pkg::CAPACITY_DEF;
   localparam int CNT_W          = $clog2(CAPACITY + 1);
   localparam int VALUE_W        = spq_pkg::VALUE_W;
   localparam int PRIO_IN_W      = spq_pkg::PRIO_IN_W;
   localparam int RANDOM_ITEMS   = 1125;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_LIMIT    = 200;
   localparam int TAIL_CYCLES    = 30;

   typedef struct {
      logic signed [VALUE_W-1:0] popped;
      spq_pkg::status_type       status;
      logic [CNT_W-1:0]          occupancy;
      logic [CNT_W-1:0]          removed;
   } pq_outcome_type;

   class pq_shadow;
      logic signed [VALUE_W-1:0] vals[CAPACITY];
      logic [PRIO_IN_W-1:0]      prios[CAPACITY];
      int                        count;
      pq_outcome_type            due[$];
      int                        errors;
      int                        op_seen[4];
      int                        full_hits;
      int                        empty_hits;
      int                        deleted;
      int                        peak;

      function void note_request(spq_pkg::func_type f, logic signed [VALUE_W-1:0] v,
                                 logic [PRIO_IN_W-1:0] p);
         pq_outcome_type r;
         int             pos;
         int             keep;
         r.popped  = '0;
         r.status  = spq_pkg::STATUS_OK;
         r.removed = '0;
         op_seen[f]++;
         case (f)
            spq_pkg::FUNC_PUSH, spq_pkg::FUNC_INSERT: begin
               if (count >= CAPACITY) begin
                  r.status = spq_pkg::STATUS_FULL;
                  full_hits++;
               end else begin
                  pos = count;
                  if (f == spq_pkg::FUNC_INSERT)
                     for (int i = count - 1; i >= 0; i--)
                        if (prios[i] < p) pos = i;
                  for (int i = count; i > pos; i--) begin
                     vals[i]  = vals[i-1];
                     prios[i] = prios[i-1];
                  end
                  vals[pos]  = v;
                  prios[pos] = (f == spq_pkg::FUNC_INSERT) ? p : '0;
                  count++;
               end
            end
            spq_pkg::FUNC_POP: begin
               if (count == 0) begin
                  r.status = spq_pkg::STATUS_EMPTY;
                  empty_hits++;
               end else begin
                  r.popped = vals[0];
                  for (int i = 1; i < count; i++) begin
                     vals[i-1]  = vals[i];
                     prios[i-1] = prios[i];
                  end
                  count--;
                  r.removed = CNT_W'(1);
               end
            end
            default: begin
               keep = 0;
               for (int i = 0; i < count; i++) begin
                  if (prios[i] == p) begin
                     r.removed++;
                  end else begin
                     vals[keep]  = vals[i];
                     prios[keep] = prios[i];
                     keep++;
                  end
               end
               count = keep;
               deleted += r.removed;
            end
         endcase
         r.occupancy = CNT_W'(count);
         if (count > peak) peak = count;
         due.push_back(r);
      endfunction

      function void check_response(logic signed [VALUE_W-1:0] popped,
                                   logic [spq_pkg::STATUS_W-1:0] status,
                                   logic [CNT_W-1:0] occupancy,
                                   logic [CNT_W-1:0] removed);
         pq_outcome_type e;
         if (due.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         e = due.pop_front();
         if (popped !== e.popped) begin
            $error("popped_value: expected %0d, got %0d", e.popped, popped);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (occupancy !== e.occupancy) begin
            $error("occupancy: expected %0d, got %0d", e.occupancy, occupancy);
            errors++;
         end
         if (removed !== e.removed) begin
            $error("removed_count: expected %0d, got %0d", e.removed, removed);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [spq_pkg::FUNC_W-1:0]        req_func = '0;
   logic signed [VALUE_W-1:0]         req_item_value = '0;
   logic [PRIO_IN_W-1:0]              req_item_priority = '0;
   logic                              rsp_strobe;
   logic signed [VALUE_W-1:0]         rsp_popped_value;
   logic [spq_pkg::STATUS_W-1:0]      rsp_status;
   logic [CNT_W-1:0]                  rsp_occupancy;
   logic [CNT_W-1:0]                  rsp_removed_count;

   pq_shadow sb = new;
   int       idle_cycles = 0;

   sorted_priority_queue u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_strobe        (rsp_strobe),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_response(rsp_popped_value, rsp_status, rsp_occupancy,
                              rsp_removed_count);
         if (start && !busy)
            sb.note_request(spq_pkg::func_type'(req_func), req_item_value,
                            req_item_priority);
      end
      if (rsp_strobe || (start && !busy && !reset)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_sorted_priority_queue: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // start stays high on a zero gap so the next beat goes out as soon as busy drops
   task automatic send_request(input spq_pkg::func_type f,
                               input logic signed [VALUE_W-1:0] v,
                               input logic [PRIO_IN_W-1:0] p, input int gap);
      req_func          <= f;
      req_item_value    <= v;
      req_item_priority <= p;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat (gap - 1) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      send_request(spq_pkg::FUNC_POP, 32'sd0, 8'd0, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_DELETE, 32'sd0, 8'd5, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 8'd255, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'h8000_0000, 8'd0, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 8'd200, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'sd1, 8'd0, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'sd2, 8'd128, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'sd3, 8'd128, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_DELETE, 32'sd0, 8'd128, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_DELETE, 32'sd0, 8'd77, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_POP, 32'sd0, 8'd0, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_PUSH, 32'sd4, 8'd9, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'sd5, 8'd3, $urandom_range(0, 7));
      // five entries held here; eleven more fill the store
      for (int k = 0; k < 11; k++)
         send_request(spq_pkg::FUNC_INSERT, $urandom,
                      PRIO_IN_W'($urandom_range(0, 255)), $urandom_range(0, 3));
      send_request(spq_pkg::FUNC_PUSH, 32'sd6, 8'd0, $urandom_range(0, 7));
      send_request(spq_pkg::FUNC_INSERT, 32'sd7, 8'd255, $urandom_range(0, 7));
   endtask

   task automatic run_random(input int n);
      spq_pkg::func_type         f;
      logic signed [VALUE_W-1:0] v;
      logic [PRIO_IN_W-1:0]      p;
      int                        mode;
      int                        pick;
      int                        burst;
      mode  = 0;
      burst = 0;
      for (int k = 0; k < n; k++) begin
         if (k % 40 == 0) begin
            mode  = $urandom_range(0, 2);
            burst = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         case (mode)
            0:       f = pick < 15 ? spq_pkg::FUNC_PUSH : pick < 70 ? spq_pkg::FUNC_INSERT :
                         pick < 90 ? spq_pkg::FUNC_POP : spq_pkg::FUNC_DELETE;
            1:       f = pick < 10 ? spq_pkg::FUNC_PUSH : pick < 35 ? spq_pkg::FUNC_INSERT :
                         pick < 90 ? spq_pkg::FUNC_POP : spq_pkg::FUNC_DELETE;
            default: f = pick < 20 ? spq_pkg::FUNC_PUSH : pick < 50 ? spq_pkg::FUNC_INSERT :
                         pick < 80 ? spq_pkg::FUNC_POP : spq_pkg::FUNC_DELETE;
         endcase
         case ($urandom_range(0, 9))
            0:       p = 8'd0;
            1:       p = 8'd255;
            2, 3, 4: p = PRIO_IN_W'($urandom_range(0, 3));
            default: p = PRIO_IN_W'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'sd0;
               default: v = -32'sd1;
            endcase
         end else begin
            v = $urandom;
         end
         send_request(f, v, p, burst ? 0 : $urandom_range(0, 7));
      end
   endtask

   initial begin
      int waited;
      waited = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(RANDOM_ITEMS);
      start <= 1'b0;
      while (sb.due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.due.size() != 0) begin
         $error("%0d responses never arrived", sb.due.size());
         sb.errors++;
      end
      $display("ran %0d push, %0d insert, %0d pop, %0d delete requests",
               sb.op_seen[spq_pkg::FUNC_PUSH], sb.op_seen[spq_pkg::FUNC_INSERT],
               sb.op_seen[spq_pkg::FUNC_POP], sb.op_seen[spq_pkg::FUNC_DELETE]);
      $display("%0d dropped on full, %0d pops on empty, %0d entries deleted, peak fill %0d",
               sb.full_hits, sb.empty_hits, sb.deleted, sb.peak);
      if (sb.errors == 0) begin
         $display("tb_sorted_priority_queue: PASS");
      end else begin
         $display("tb_sorted_priority_queue: FAIL");
      end
      $finish;
   end

endmodule
